// ===== rtl/net_bbox_hpwl_accumulator_core_defines.svh =====
// Assertion macros used by the checker file of this block.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low,
// so the module that uses them must have signals named clk and rst_n.
`ifndef NET_BBOX_HPWL_ACCUMULATOR_CORE_DEFINES_SVH
`define NET_BBOX_HPWL_ACCUMULATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPWL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpwl assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define HPWL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpwl assertion failed in the next cycle");

`endif

// ===== rtl/hpwl_pkg.sv =====
package hpwl_pkg;

    // Default widths of the coordinate and pin id fields.
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int PIN_ID_WIDTH_DEF = 24;

    // The running total is fixed at 63 bits and saturates at its maximum.
    localparam int TOTAL_WIDTH = 63;

    // A net needs this many pins before its length counts.
    localparam int MIN_PINS_FOR_LENGTH = 2;

    // The pin counter saturates at the threshold above.
    localparam int PINS_SEEN_WIDTH = 2;
    localparam logic [PINS_SEEN_WIDTH-1:0] PINS_SEEN_MAX =
        PINS_SEEN_WIDTH'(MIN_PINS_FOR_LENGTH);

    // Control flags that travel with one net result down the pipeline.
    typedef struct packed {
        logic is_empty;
        logic multi_pin;
        logic restart;
    } hpwl_ctrl_t;

endpackage

// ===== rtl/hpwl_box_track.sv =====
module hpwl_box_track
    import hpwl_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int PIN_ID_WIDTH = PIN_ID_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  pin_x,
    input  logic signed [COORD_WIDTH-1:0]  pin_y,
    input  logic        [PIN_ID_WIDTH-1:0] pin_id,
    input  logic                           net_last,
    input  logic                           empty_net,
    input  logic                           restart_total,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_WIDTH-1:0]  out_min_x,
    output logic signed [COORD_WIDTH-1:0]  out_max_x,
    output logic signed [COORD_WIDTH-1:0]  out_min_y,
    output logic signed [COORD_WIDTH-1:0]  out_max_y,
    output logic        [PIN_ID_WIDTH-1:0] out_left,
    output logic        [PIN_ID_WIDTH-1:0] out_right,
    output logic        [PIN_ID_WIDTH-1:0] out_bottom,
    output logic        [PIN_ID_WIDTH-1:0] out_top,
    output hpwl_ctrl_t                     out_ctrl
);

    // Input register.
    logic                           a_valid_reg, a_valid_next;
    logic signed [COORD_WIDTH-1:0]  x_reg, y_reg;
    logic        [PIN_ID_WIDTH-1:0] id_reg;
    logic                           last_reg, empty_reg, restart_reg;

    // Running box of the current net.
    logic signed [COORD_WIDTH-1:0]  run_min_x_reg, run_max_x_reg;
    logic signed [COORD_WIDTH-1:0]  run_min_y_reg, run_max_y_reg;
    logic        [PIN_ID_WIDTH-1:0] arg_min_x_reg, arg_max_x_reg;
    logic        [PIN_ID_WIDTH-1:0] arg_min_y_reg, arg_max_y_reg;
    logic [PINS_SEEN_WIDTH-1:0]     pins_seen_reg, pins_seen_next;
    logic                           restart_pend_reg, restart_pend_next;

    // Snapshot register handed to the length stage.
    logic                           b_valid_reg, b_valid_next;
    logic signed [COORD_WIDTH-1:0]  b_min_x_reg, b_max_x_reg, b_min_y_reg, b_max_y_reg;
    logic        [PIN_ID_WIDTH-1:0] b_left_reg, b_right_reg, b_bottom_reg, b_top_reg;
    hpwl_ctrl_t                     b_ctrl_reg;

    logic                           in_fire, a_fire, emit, b_take, first_pin;
    logic signed [COORD_WIDTH-1:0]  min_x_next, max_x_next, min_y_next, max_y_next;
    logic        [PIN_ID_WIDTH-1:0] left_next, right_next, bottom_next, top_next;
    logic [PINS_SEEN_WIDTH-1:0]     pins_inc;
    hpwl_ctrl_t                     ctrl_next;

    always_comb
    begin
        emit     = empty_reg || last_reg;
        b_take   = !b_valid_reg || out_ready;
        a_fire   = a_valid_reg && (!emit || b_take);
        in_ready = !a_valid_reg || a_fire;
        in_fire  = in_valid && in_ready;

        first_pin = (pins_seen_reg == '0);

        // Strict compares keep the earlier pin on a tie.
        if (first_pin || (x_reg < run_min_x_reg))
        begin
            min_x_next = x_reg;
            left_next  = id_reg;
        end
        else
        begin
            min_x_next = run_min_x_reg;
            left_next  = arg_min_x_reg;
        end
        if (first_pin || (x_reg > run_max_x_reg))
        begin
            max_x_next = x_reg;
            right_next = id_reg;
        end
        else
        begin
            max_x_next = run_max_x_reg;
            right_next = arg_max_x_reg;
        end
        if (first_pin || (y_reg < run_min_y_reg))
        begin
            min_y_next  = y_reg;
            bottom_next = id_reg;
        end
        else
        begin
            min_y_next  = run_min_y_reg;
            bottom_next = arg_min_y_reg;
        end
        if (first_pin || (y_reg > run_max_y_reg))
        begin
            max_y_next = y_reg;
            top_next   = id_reg;
        end
        else
        begin
            max_y_next = run_max_y_reg;
            top_next   = arg_max_y_reg;
        end

        pins_inc = (pins_seen_reg == PINS_SEEN_MAX) ? PINS_SEEN_MAX
                                                    : pins_seen_reg + 1'b1;

        ctrl_next.is_empty  = empty_reg;
        ctrl_next.multi_pin = !empty_reg && (pins_inc >= PINS_SEEN_MAX);
        ctrl_next.restart   = restart_reg || restart_pend_reg;

        a_valid_next = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_reg);

        pins_seen_next    = pins_seen_reg;
        restart_pend_next = restart_pend_reg;
        if (a_fire)
        begin
            pins_seen_next    = emit ? '0 : pins_inc;
            restart_pend_next = emit ? 1'b0 : (restart_pend_reg || restart_reg);
        end

        if (a_fire && emit)
            b_valid_next = 1'b1;
        else if (out_ready)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            pins_seen_reg    <= '0;
            restart_pend_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg      <= a_valid_next;
            b_valid_reg      <= b_valid_next;
            pins_seen_reg    <= pins_seen_next;
            restart_pend_reg <= restart_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg       <= pin_x;
            y_reg       <= pin_y;
            id_reg      <= pin_id;
            last_reg    <= net_last;
            empty_reg   <= empty_net;
            restart_reg <= restart_total;
        end
        if (a_fire && !empty_reg)
        begin
            run_min_x_reg <= min_x_next;
            run_max_x_reg <= max_x_next;
            run_min_y_reg <= min_y_next;
            run_max_y_reg <= max_y_next;
            arg_min_x_reg <= left_next;
            arg_max_x_reg <= right_next;
            arg_min_y_reg <= bottom_next;
            arg_max_y_reg <= top_next;
        end
        if (a_fire && emit)
        begin
            b_ctrl_reg <= ctrl_next;
            if (empty_reg)
            begin
                b_min_x_reg  <= '0;
                b_max_x_reg  <= '0;
                b_min_y_reg  <= '0;
                b_max_y_reg  <= '0;
                b_left_reg   <= '0;
                b_right_reg  <= '0;
                b_bottom_reg <= '0;
                b_top_reg    <= '0;
            end
            else
            begin
                b_min_x_reg  <= min_x_next;
                b_max_x_reg  <= max_x_next;
                b_min_y_reg  <= min_y_next;
                b_max_y_reg  <= max_y_next;
                b_left_reg   <= left_next;
                b_right_reg  <= right_next;
                b_bottom_reg <= bottom_next;
                b_top_reg    <= top_next;
            end
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_min_x  = b_min_x_reg;
    assign out_max_x  = b_max_x_reg;
    assign out_min_y  = b_min_y_reg;
    assign out_max_y  = b_max_y_reg;
    assign out_left   = b_left_reg;
    assign out_right  = b_right_reg;
    assign out_bottom = b_bottom_reg;
    assign out_top    = b_top_reg;
    assign out_ctrl   = b_ctrl_reg;

endmodule

// ===== rtl/hpwl_span_sum.sv =====
module hpwl_span_sum
    import hpwl_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int PIN_ID_WIDTH = PIN_ID_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  in_min_x,
    input  logic signed [COORD_WIDTH-1:0]  in_max_x,
    input  logic signed [COORD_WIDTH-1:0]  in_min_y,
    input  logic signed [COORD_WIDTH-1:0]  in_max_y,
    input  logic        [PIN_ID_WIDTH-1:0] in_left,
    input  logic        [PIN_ID_WIDTH-1:0] in_right,
    input  logic        [PIN_ID_WIDTH-1:0] in_bottom,
    input  logic        [PIN_ID_WIDTH-1:0] in_top,
    input  hpwl_ctrl_t                     in_ctrl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_WIDTH-1:0]  out_min_x,
    output logic signed [COORD_WIDTH-1:0]  out_max_x,
    output logic signed [COORD_WIDTH-1:0]  out_min_y,
    output logic signed [COORD_WIDTH-1:0]  out_max_y,
    output logic        [PIN_ID_WIDTH-1:0] out_left,
    output logic        [PIN_ID_WIDTH-1:0] out_right,
    output logic        [PIN_ID_WIDTH-1:0] out_bottom,
    output logic        [PIN_ID_WIDTH-1:0] out_top,
    output logic        [COORD_WIDTH:0]    out_len,
    output hpwl_ctrl_t                     out_ctrl
);

    localparam int LEN_WIDTH = COORD_WIDTH + 1;

    logic                           valid_reg, valid_next;
    logic signed [COORD_WIDTH-1:0]  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic        [PIN_ID_WIDTH-1:0] left_reg, right_reg, bottom_reg, top_reg;
    logic        [LEN_WIDTH-1:0]    len_reg, len_next;
    hpwl_ctrl_t                     ctrl_reg;

    logic                           load;
    logic        [LEN_WIDTH-1:0]    span_x, span_y;

    always_comb
    begin
        in_ready = !valid_reg || out_ready;
        load     = in_valid && in_ready;

        // A span of a valid box is never negative, so it fits one extra bit unsigned.
        span_x = {in_max_x[COORD_WIDTH-1], in_max_x} - {in_min_x[COORD_WIDTH-1], in_min_x};
        span_y = {in_max_y[COORD_WIDTH-1], in_max_y} - {in_min_y[COORD_WIDTH-1], in_min_y};
        len_next = in_ctrl.multi_pin ? (span_x + span_y) : '0;

        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            min_x_reg  <= in_min_x;
            max_x_reg  <= in_max_x;
            min_y_reg  <= in_min_y;
            max_y_reg  <= in_max_y;
            left_reg   <= in_left;
            right_reg  <= in_right;
            bottom_reg <= in_bottom;
            top_reg    <= in_top;
            len_reg    <= len_next;
            ctrl_reg   <= in_ctrl;
        end
    end

    assign out_valid  = valid_reg;
    assign out_min_x  = min_x_reg;
    assign out_max_x  = max_x_reg;
    assign out_min_y  = min_y_reg;
    assign out_max_y  = max_y_reg;
    assign out_left   = left_reg;
    assign out_right  = right_reg;
    assign out_bottom = bottom_reg;
    assign out_top    = top_reg;
    assign out_len    = len_reg;
    assign out_ctrl   = ctrl_reg;

endmodule

// ===== rtl/hpwl_total_acc.sv =====
module hpwl_total_acc
    import hpwl_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int PIN_ID_WIDTH = PIN_ID_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  in_min_x,
    input  logic signed [COORD_WIDTH-1:0]  in_max_x,
    input  logic signed [COORD_WIDTH-1:0]  in_min_y,
    input  logic signed [COORD_WIDTH-1:0]  in_max_y,
    input  logic        [PIN_ID_WIDTH-1:0] in_left,
    input  logic        [PIN_ID_WIDTH-1:0] in_right,
    input  logic        [PIN_ID_WIDTH-1:0] in_bottom,
    input  logic        [PIN_ID_WIDTH-1:0] in_top,
    input  logic        [COORD_WIDTH:0]    in_len,
    input  hpwl_ctrl_t                     in_ctrl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_WIDTH-1:0]  box_min_x,
    output logic signed [COORD_WIDTH-1:0]  box_max_x,
    output logic signed [COORD_WIDTH-1:0]  box_min_y,
    output logic signed [COORD_WIDTH-1:0]  box_max_y,
    output logic        [PIN_ID_WIDTH-1:0] left_pin,
    output logic        [PIN_ID_WIDTH-1:0] right_pin,
    output logic        [PIN_ID_WIDTH-1:0] bottom_pin,
    output logic        [PIN_ID_WIDTH-1:0] top_pin,
    output logic        [COORD_WIDTH:0]    net_length,
    output logic        [TOTAL_WIDTH-1:0]  total_length,
    output logic                           net_is_empty
);

    logic                           valid_reg, valid_next;
    logic        [TOTAL_WIDTH-1:0]  total_reg, total_next;
    logic signed [COORD_WIDTH-1:0]  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic        [PIN_ID_WIDTH-1:0] left_reg, right_reg, bottom_reg, top_reg;
    logic        [COORD_WIDTH:0]    len_reg;
    logic                           empty_reg;

    logic                           load;
    logic        [TOTAL_WIDTH-1:0]  total_base;
    logic        [TOTAL_WIDTH:0]    total_sum;

    always_comb
    begin
        in_ready = !valid_reg || out_ready;
        load     = in_valid && in_ready;

        // The length is zero for empty and single-pin nets, so they add nothing to the total.
        total_base = in_ctrl.restart ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + (TOTAL_WIDTH+1)'(in_len);
        total_next = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];

        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            min_x_reg  <= in_min_x;
            max_x_reg  <= in_max_x;
            min_y_reg  <= in_min_y;
            max_y_reg  <= in_max_y;
            left_reg   <= in_left;
            right_reg  <= in_right;
            bottom_reg <= in_bottom;
            top_reg    <= in_top;
            len_reg    <= in_len;
            empty_reg  <= in_ctrl.is_empty;
        end
    end

    assign out_valid    = valid_reg;
    assign box_min_x    = min_x_reg;
    assign box_max_x    = max_x_reg;
    assign box_min_y    = min_y_reg;
    assign box_max_y    = max_y_reg;
    assign left_pin     = left_reg;
    assign right_pin    = right_reg;
    assign bottom_pin   = bottom_reg;
    assign top_pin      = top_reg;
    assign net_length   = len_reg;
    assign total_length = total_reg;
    assign net_is_empty = empty_reg;

endmodule

// ===== rtl/net_bbox_hpwl_accumulator_core.sv =====
// Net bounding box and half-perimeter wirelength accumulator. Pins arrive one per input
// transaction, grouped into nets by net_last; a transaction with empty_net set stands for a
// net with no pins and discards any pins of an unfinished net. Every net end produces one
// output transaction with the bounding box, the ids of the first pins to reach each extreme
// (ties keep the earlier pin), the net length (x span plus y span, zero below two pins) and
// the running total, which saturates at 2^63-1. restart_total clears the total before its
// own transaction is counted, even when that transaction does not end a net. The block takes
// one transaction per clock cycle when not stalled; a net end passes the input, snapshot,
// span and total registers in turn. The cycle is set by the box update (four signed compares
// against the running box), the length adder and the 63-bit saturating total adder, each of
// which sits in a stage of its own. Each stage stalls only when its downstream register is
// full and not being drained, so output backpressure propagates to in_ready.
module net_bbox_hpwl_accumulator_core
    import hpwl_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int PIN_ID_WIDTH = PIN_ID_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Pin input channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  pin_x,
    input  logic signed [COORD_WIDTH-1:0]  pin_y,
    input  logic        [PIN_ID_WIDTH-1:0] pin_id,
    input  logic                           net_last,
    input  logic                           empty_net,
    input  logic                           restart_total,
    // Net result channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_WIDTH-1:0]  box_min_x,
    output logic signed [COORD_WIDTH-1:0]  box_max_x,
    output logic signed [COORD_WIDTH-1:0]  box_min_y,
    output logic signed [COORD_WIDTH-1:0]  box_max_y,
    output logic        [PIN_ID_WIDTH-1:0] left_pin,
    output logic        [PIN_ID_WIDTH-1:0] right_pin,
    output logic        [PIN_ID_WIDTH-1:0] bottom_pin,
    output logic        [PIN_ID_WIDTH-1:0] top_pin,
    output logic        [COORD_WIDTH:0]    net_length,
    output logic        [TOTAL_WIDTH-1:0]  total_length,
    output logic                           net_is_empty
);

    // Box tracker to span adder: one snapshot per net end.
    logic                           box_valid, box_ready;
    logic signed [COORD_WIDTH-1:0]  box_min_x_s, box_max_x_s, box_min_y_s, box_max_y_s;
    logic        [PIN_ID_WIDTH-1:0] box_left_s, box_right_s, box_bottom_s, box_top_s;
    hpwl_ctrl_t                     box_ctrl_s;

    // Span adder to total accumulator.
    logic                           len_valid, len_ready;
    logic signed [COORD_WIDTH-1:0]  len_min_x_s, len_max_x_s, len_min_y_s, len_max_y_s;
    logic        [PIN_ID_WIDTH-1:0] len_left_s, len_right_s, len_bottom_s, len_top_s;
    logic        [COORD_WIDTH:0]    len_value_s;
    hpwl_ctrl_t                     len_ctrl_s;

    // The input register and the running box live in the tracker. Transactions that do
    // not end a net only update the box; a pending restart is carried to the next net end.
    hpwl_box_track #(
        .COORD_WIDTH  (COORD_WIDTH),
        .PIN_ID_WIDTH (PIN_ID_WIDTH)
    ) u_box_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pin_x         (pin_x),
        .pin_y         (pin_y),
        .pin_id        (pin_id),
        .net_last      (net_last),
        .empty_net     (empty_net),
        .restart_total (restart_total),
        .out_valid     (box_valid),
        .out_ready     (box_ready),
        .out_min_x     (box_min_x_s),
        .out_max_x     (box_max_x_s),
        .out_min_y     (box_min_y_s),
        .out_max_y     (box_max_y_s),
        .out_left      (box_left_s),
        .out_right     (box_right_s),
        .out_bottom    (box_bottom_s),
        .out_top       (box_top_s),
        .out_ctrl      (box_ctrl_s)
    );

    // The span adder forms the net length from the finished box.
    hpwl_span_sum #(
        .COORD_WIDTH  (COORD_WIDTH),
        .PIN_ID_WIDTH (PIN_ID_WIDTH)
    ) u_span_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (box_valid),
        .in_ready   (box_ready),
        .in_min_x   (box_min_x_s),
        .in_max_x   (box_max_x_s),
        .in_min_y   (box_min_y_s),
        .in_max_y   (box_max_y_s),
        .in_left    (box_left_s),
        .in_right   (box_right_s),
        .in_bottom  (box_bottom_s),
        .in_top     (box_top_s),
        .in_ctrl    (box_ctrl_s),
        .out_valid  (len_valid),
        .out_ready  (len_ready),
        .out_min_x  (len_min_x_s),
        .out_max_x  (len_max_x_s),
        .out_min_y  (len_min_y_s),
        .out_max_y  (len_max_y_s),
        .out_left   (len_left_s),
        .out_right  (len_right_s),
        .out_bottom (len_bottom_s),
        .out_top    (len_top_s),
        .out_len    (len_value_s),
        .out_ctrl   (len_ctrl_s)
    );

    // The accumulator holds the saturating total and doubles as the output register.
    hpwl_total_acc #(
        .COORD_WIDTH  (COORD_WIDTH),
        .PIN_ID_WIDTH (PIN_ID_WIDTH)
    ) u_total_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (len_valid),
        .in_ready     (len_ready),
        .in_min_x     (len_min_x_s),
        .in_max_x     (len_max_x_s),
        .in_min_y     (len_min_y_s),
        .in_max_y     (len_max_y_s),
        .in_left      (len_left_s),
        .in_right     (len_right_s),
        .in_bottom    (len_bottom_s),
        .in_top       (len_top_s),
        .in_len       (len_value_s),
        .in_ctrl      (len_ctrl_s),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .box_min_x    (box_min_x),
        .box_max_x    (box_max_x),
        .box_min_y    (box_min_y),
        .box_max_y    (box_max_y),
        .left_pin     (left_pin),
        .right_pin    (right_pin),
        .bottom_pin   (bottom_pin),
        .top_pin      (top_pin),
        .net_length   (net_length),
        .total_length (total_length),
        .net_is_empty (net_is_empty)
    );

endmodule

// ===== rtl/hpwl_checker.sv =====
`include "net_bbox_hpwl_accumulator_core_defines.svh"

module hpwl_checker
    import hpwl_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int PIN_ID_WIDTH = PIN_ID_WIDTH_DEF
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [COORD_WIDTH-1:0]  box_min_x,
    input logic signed [COORD_WIDTH-1:0]  box_max_x,
    input logic signed [COORD_WIDTH-1:0]  box_min_y,
    input logic signed [COORD_WIDTH-1:0]  box_max_y,
    input logic        [PIN_ID_WIDTH-1:0] left_pin,
    input logic        [PIN_ID_WIDTH-1:0] right_pin,
    input logic        [PIN_ID_WIDTH-1:0] bottom_pin,
    input logic        [PIN_ID_WIDTH-1:0] top_pin,
    input logic        [COORD_WIDTH:0]    net_length,
    input logic        [TOTAL_WIDTH-1:0]  total_length,
    input logic                           net_is_empty
);

    logic box_zero;
    logic ids_zero;

    assign box_zero = (box_min_x == '0) && (box_max_x == '0) &&
                      (box_min_y == '0) && (box_max_y == '0);
    assign ids_zero = (left_pin == '0) && (right_pin == '0) &&
                      (bottom_pin == '0) && (top_pin == '0);

    // A stalled result stays offered.
    `HPWL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // An empty net reports an all-zero box, zero pin ids and zero length.
    `HPWL_ASSERT_SAME(a_empty_zero, out_valid && net_is_empty, box_zero && ids_zero && net_length == 0)

    // A box built from real pins is never inverted.
    `HPWL_ASSERT_SAME(a_box_order, out_valid && !net_is_empty, box_min_x <= box_max_x && box_min_y <= box_max_y)

    // A net that added length leaves a nonzero total behind.
    `HPWL_ASSERT_SAME(a_total_nonzero, out_valid && net_length != 0, total_length != 0)

endmodule

bind net_bbox_hpwl_accumulator_core hpwl_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .PIN_ID_WIDTH (PIN_ID_WIDTH)
) u_hpwl_checker (.*);
